// ----- hdl/nsq_pkg.sv -----
// nsq_pkg: shared types, widths and register codes for the nine-slice quad generator.
// Depends on nothing; imported by nine_slice_quad_generator.

package nsq_pkg;

  localparam int CoordW = 12;   // input and register field width
  localparam int PosW   = 14;   // screen position width
  localparam int SizeW  = 13;   // size field width on the result word
  localparam int TexW   = 15;   // texture position width, two's complement
  localparam int DiffW  = 15;   // width of size differences before the clamp
  localparam int Cells  = 9;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_BORDER_LEFT   = 3'd0,
    CFG_BORDER_TOP    = 3'd1,
    CFG_BORDER_RIGHT  = 3'd2,
    CFG_BORDER_BOTTOM = 3'd3,
    CFG_IMAGE_LEFT    = 3'd4,
    CFG_IMAGE_TOP     = 3'd5,
    CFG_IMAGE_RIGHT   = 3'd6,
    CFG_IMAGE_BOTTOM  = 3'd7
  } cfg_idx_t;

  // one column (or row) of the 3x3 grid
  typedef struct packed {
    logic [PosW-1:0]   pos;    // screen position
    logic [CoordW-1:0] size;   // screen size
    logic [TexW-1:0]   tpos;   // texture position
    logic [CoordW-1:0] tsize;  // texture size
  } slice_t;

  // grid row of a cell index
  function automatic logic [1:0] cell_row(input logic [3:0] cell_no);
    logic [1:0] r;
    case (cell_no)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // grid column of a cell index
  function automatic logic [1:0] cell_col(input logic [3:0] cell_no);
    logic [1:0] c;
    case (cell_no)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      4'd2, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

  // clamp a signed difference at zero and keep the low field bits
  function automatic logic [CoordW-1:0] clamp0(input logic [DiffW-1:0] d);
    return d[DiffW-1] ? '0 : d[CoordW-1:0];
  endfunction

endpackage

// ----- hdl/nine_slice_quad_generator.sv -----
// The first quad of an element passes stages 1, 2 and 3, the emitter and the output register.
// Throughput: one quad word per cycle while out_ready is high; an element holds the emitter
// for one quad per nonempty cell (1 to 9), and an element with no cells sends no quad.
// The per-cell emitter sets the rate; the three stages in front of it overlap with it.
// Reset: synchronous, active low; clears all stage valid bits and the eight registers.
// Depends on nsq_pkg.

module nine_slice_quad_generator
  import nsq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [CoordW-1:0]        cfg_wdata,
  // element request words
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CoordW-1:0]        in_indent,
  input  logic [CoordW-1:0]        in_elem_width,
  input  logic [CoordW-1:0]        in_elem_height,
  input  logic signed [CoordW-1:0] in_offset_x,
  input  logic signed [CoordW-1:0] in_offset_y,
  input  logic                     in_tile_mode,
  // quad words
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PosW-1:0]          out_screen_x,
  output logic [PosW-1:0]          out_screen_y,
  output logic [SizeW-1:0]         out_screen_w,
  output logic [SizeW-1:0]         out_screen_h,
  output logic signed [TexW-1:0]   out_tex_x,
  output logic signed [TexW-1:0]   out_tex_y,
  output logic [SizeW-1:0]         out_tex_w,
  output logic [SizeW-1:0]         out_tex_h,
  output logic                     out_tiled,
  output logic [3:0]               out_cell_res,
  output logic                     out_last_quad
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CoordW-1:0] border_left_r, border_top_r, border_right_r, border_bottom_r;
  logic [CoordW-1:0] image_left_r, image_top_r, image_right_r, image_bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      border_left_r   <= '0;
      border_top_r    <= '0;
      border_right_r  <= '0;
      border_bottom_r <= '0;
      image_left_r    <= '0;
      image_top_r     <= '0;
      image_right_r   <= '0;
      image_bottom_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BORDER_LEFT:   border_left_r   <= cfg_wdata;
        CFG_BORDER_TOP:    border_top_r    <= cfg_wdata;
        CFG_BORDER_RIGHT:  border_right_r  <= cfg_wdata;
        CFG_BORDER_BOTTOM: border_bottom_r <= cfg_wdata;
        CFG_IMAGE_LEFT:    image_left_r    <= cfg_wdata;
        CFG_IMAGE_TOP:     image_top_r     <= cfg_wdata;
        CFG_IMAGE_RIGHT:   image_right_r   <= cfg_wdata;
        CFG_IMAGE_BOTTOM:  image_bottom_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage flow control. Each stage loads when it is empty or hands its word on.
  // The emitter drains one cell per output slot; an element with no cells is
  // dropped at stage 3 without entering the emitter.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, e_v_r, out_v_r;
  logic out_load, e_fire, e_last, e_free;
  logic s3_go, s3_free, s2_go, s2_free, s1_go, s1_free, in_take;
  logic [Cells-1:0] s3_mask_r, e_mask_r;

  assign out_load = !out_v_r || out_ready;
  assign e_fire   = e_v_r && out_load;
  assign e_free   = !e_v_r || (e_fire && e_last);
  assign s3_go    = s3_v_r && ((s3_mask_r == '0) || e_free);
  assign s3_free  = !s3_v_r || s3_go;
  assign s2_go    = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s2_go;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s1_go;
  assign in_ready = s1_free;
  assign in_take  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage 1: net width, texture origin, source rectangle span
  // ---------------------------------------------------------------------------
  logic [CoordW-1:0] s1_indent_r, s1_h_r;
  logic [CoordW:0]   s1_w_r, s1_dtx_r, s1_dty_r;   // signed 13-bit differences
  logic [TexW-1:0]   s1_tx0_r, s1_ty0_r;
  logic              s1_tmode_r;

  logic [CoordW:0]   w_nxt, dtx_nxt, dty_nxt;
  logic [TexW-1:0]   tx0_nxt, ty0_nxt;

  always_comb begin
    w_nxt   = {1'b0, in_elem_width} - {1'b0, in_indent};
    dtx_nxt = {1'b0, image_right_r} - {1'b0, image_left_r};
    dty_nxt = {1'b0, image_bottom_r} - {1'b0, image_top_r};
    tx0_nxt = {3'b000, image_left_r} + {{3{in_offset_x[CoordW-1]}}, in_offset_x};
    ty0_nxt = {3'b000, image_top_r}  + {{3{in_offset_y[CoordW-1]}}, in_offset_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_free) s1_v_r <= in_take;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_indent_r <= in_indent;
      s1_h_r      <= in_elem_height;
      s1_w_r      <= w_nxt;
      s1_dtx_r    <= dtx_nxt;
      s1_dty_r    <= dty_nxt;
      s1_tx0_r    <= tx0_nxt;
      s1_ty0_r    <= ty0_nxt;
      s1_tmode_r  <= in_tile_mode;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: inner screen and texture sizes, clamped at zero
  // ---------------------------------------------------------------------------
  logic [CoordW-1:0] s2_indent_r, s2_inx_r, s2_iny_r, s2_itx_r, s2_ity_r;
  logic [TexW-1:0]   s2_tx0_r, s2_ty0_r;
  logic              s2_tmode_r;

  logic [DiffW-1:0]  dx_nxt, dy_nxt, dtxi_nxt, dtyi_nxt;

  always_comb begin
    dx_nxt   = {{2{s1_w_r[CoordW]}}, s1_w_r}
             - {3'b000, border_left_r} - {3'b000, border_right_r};
    dy_nxt   = {3'b000, s1_h_r}
             - {3'b000, border_top_r} - {3'b000, border_bottom_r};
    dtxi_nxt = {{2{s1_dtx_r[CoordW]}}, s1_dtx_r}
             - {3'b000, border_left_r} - {3'b000, border_right_r};
    dtyi_nxt = {{2{s1_dty_r[CoordW]}}, s1_dty_r}
             - {3'b000, border_top_r} - {3'b000, border_bottom_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (s2_free) s2_v_r <= s1_go;
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_indent_r <= s1_indent_r;
      s2_inx_r    <= clamp0(dx_nxt);
      s2_iny_r    <= clamp0(dy_nxt);
      s2_itx_r    <= clamp0(dtxi_nxt);
      s2_ity_r    <= clamp0(dtyi_nxt);
      s2_tx0_r    <= s1_tx0_r;
      s2_ty0_r    <= s1_ty0_r;
      s2_tmode_r  <= s1_tmode_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: column and row geometry, nonempty cell mask
  // ---------------------------------------------------------------------------
  slice_t s3_col_r [3];
  slice_t s3_row_r [3];
  logic   s3_tmode_r;

  slice_t           col_nxt [3];
  slice_t           row_nxt [3];
  logic [Cells-1:0] mask_nxt;

  always_comb begin
    col_nxt[0].pos   = {2'b00, s2_indent_r};
    col_nxt[1].pos   = {2'b00, s2_indent_r} + {2'b00, border_left_r};
    col_nxt[2].pos   = {2'b00, s2_indent_r} + {2'b00, border_left_r} + {2'b00, s2_inx_r};
    col_nxt[0].size  = border_left_r;
    col_nxt[1].size  = s2_inx_r;
    col_nxt[2].size  = border_right_r;
    col_nxt[0].tpos  = s2_tx0_r;
    col_nxt[1].tpos  = s2_tx0_r + {3'b000, border_left_r};
    col_nxt[2].tpos  = s2_tx0_r + {3'b000, border_left_r} + {3'b000, s2_itx_r};
    col_nxt[0].tsize = border_left_r;
    col_nxt[1].tsize = s2_itx_r;
    col_nxt[2].tsize = border_right_r;

    row_nxt[0].pos   = '0;
    row_nxt[1].pos   = {2'b00, border_top_r};
    row_nxt[2].pos   = {2'b00, border_top_r} + {2'b00, s2_iny_r};
    row_nxt[0].size  = border_top_r;
    row_nxt[1].size  = s2_iny_r;
    row_nxt[2].size  = border_bottom_r;
    row_nxt[0].tpos  = s2_ty0_r;
    row_nxt[1].tpos  = s2_ty0_r + {3'b000, border_top_r};
    row_nxt[2].tpos  = s2_ty0_r + {3'b000, border_top_r} + {3'b000, s2_ity_r};
    row_nxt[0].tsize = border_top_r;
    row_nxt[1].tsize = s2_ity_r;
    row_nxt[2].tsize = border_bottom_r;

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask_nxt[r*3 + c] = (col_nxt[c].size != '0) && (row_nxt[r].size != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (s3_free) s3_v_r <= s2_go;
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_col_r   <= col_nxt;
      s3_row_r   <= row_nxt;
      s3_mask_r  <= mask_nxt;
      s3_tmode_r <= s2_tmode_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Emitter: walks the cell mask lowest cell first, one quad per output slot
  // ---------------------------------------------------------------------------
  slice_t e_col_r [3];
  slice_t e_row_r [3];
  logic   e_tmode_r;

  logic             e_load;
  logic [3:0]       sel;
  logic [1:0]       sel_r, sel_c;
  logic [Cells-1:0] sel_bit, mask_left;
  logic             corner;

  assign e_load = s3_go && (s3_mask_r != '0);

  always_comb begin
    sel = 4'd0;
    for (int i = Cells - 1; i >= 0; i--) begin
      if (e_mask_r[i]) sel = 4'(i);
    end
    sel_bit   = Cells'(1) << sel;
    mask_left = e_mask_r & ~sel_bit;
    e_last    = (mask_left == '0);
    sel_r     = cell_row(sel);
    sel_c     = cell_col(sel);
    corner    = (sel_r != 2'd1) && (sel_c != 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (e_free) begin
      e_v_r <= e_load;
    end
  end

  always_ff @(posedge clk) begin
    if (e_free && e_load) begin
      e_col_r   <= s3_col_r;
      e_row_r   <= s3_row_r;
      e_mask_r  <= s3_mask_r;
      e_tmode_r <= s3_tmode_r;
    end else if (e_fire) begin
      e_mask_r  <= mask_left;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]  oq_sx_r, oq_sy_r;
  logic [SizeW-1:0] oq_sw_r, oq_sh_r, oq_tw_r, oq_th_r;
  logic [TexW-1:0]  oq_tx_r, oq_ty_r;
  logic             oq_tiled_r, oq_last_r;
  logic [3:0]       oq_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_load) out_v_r <= e_fire;
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      oq_sx_r    <= e_col_r[sel_c].pos;
      oq_sy_r    <= e_row_r[sel_r].pos;
      oq_sw_r    <= {1'b0, e_col_r[sel_c].size};
      oq_sh_r    <= {1'b0, e_row_r[sel_r].size};
      oq_tx_r    <= e_col_r[sel_c].tpos;
      oq_ty_r    <= e_row_r[sel_r].tpos;
      oq_tw_r    <= {1'b0, e_col_r[sel_c].tsize};
      oq_th_r    <= {1'b0, e_row_r[sel_r].tsize};
      oq_tiled_r <= corner ? 1'b0 : e_tmode_r;
      oq_cell_r  <= sel;
      oq_last_r  <= e_last;
    end
  end

  assign out_valid     = out_v_r;
  assign out_screen_x  = oq_sx_r;
  assign out_screen_y  = oq_sy_r;
  assign out_screen_w  = oq_sw_r;
  assign out_screen_h  = oq_sh_r;
  assign out_tex_x     = oq_tx_r;
  assign out_tex_y     = oq_ty_r;
  assign out_tex_w     = oq_tw_r;
  assign out_tex_h     = oq_th_r;
  assign out_tiled     = oq_tiled_r;
  assign out_cell_res  = oq_cell_r;
  assign out_last_quad = oq_last_r;

`ifndef NO_ASSERTIONS
  // emitter never holds an element with nothing left to send
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    e_v_r |-> (e_mask_r != '0))
    else $error("emitter holds an empty cell mask");

  // only nonempty cells reach the output
  a_quad_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (oq_sw_r != '0) && (oq_sh_r != '0) && (oq_cell_r <= 4'd8))
    else $error("empty or out of grid quad emitted");

  // corners: untiled, texture size equals screen size
  a_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (oq_cell_r == 4'd0 || oq_cell_r == 4'd2 || oq_cell_r == 4'd6
                || oq_cell_r == 4'd8)
    |-> !oq_tiled_r && (oq_tw_r == oq_sw_r) && (oq_th_r == oq_sh_r))
    else $error("corner quad malformed");

  // a taken quad that is not the last is followed by a later cell of the same element
  a_cell_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_ready && !oq_last_r ##1 out_v_r |-> oq_cell_r > $past(oq_cell_r))
    else $error("cells out of row-major order");
`endif

endmodule
